FILE: hw/rtl/pdrg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PWM duty ramp generator.
package pdrg_pkg;

    // Field widths fixed by the stream payload.
    localparam int CMD_W   = 3;
    localparam int FIELD_W = 16;
    localparam int MODE_W  = 2;
    // Step count of a ramp: whole-percent steps, at most 100.
    localparam int STEP_W  = 7;
    // Full scale in whole percent.
    localparam int PCT_FULL = 100;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_cmd CMD_TICK = 3'd0;
    localparam t_cmd CMD_RAMP = 3'd1;
    localparam t_cmd CMD_SET  = 3'd2;
    localparam t_cmd CMD_STOP = 3'd3;
    localparam t_cmd CMD_SLOW = 3'd4;

    localparam t_mode MODE_IDLE     = 2'd0;
    localparam t_mode MODE_RAMPING  = 2'd1;
    localparam t_mode MODE_COMPLETE = 2'd2;

endpackage

FILE: hw/rtl/pwm_duty_ramp_generator_top.sv
`timescale 1ns / 1ps
// Top level of the PWM duty soft-start ramp generator: sequencer, ramp state, output register.
// Usage:
//   Slave stream carries one command per transaction: s_axis_tuser holds the
//   command (0 tick of 1 ms, 1 ramp to target, 2 instant set, 3 stop ramp,
//   4 slow start), s_axis_tdata the target duty, start duty and ramp time.
//   Duty is unsigned fixed point percent with DUTY_FRAC_BITS fraction bits.
//   Every command returns exactly one master transaction carrying the applied
//   duty, the ramp state (0 idle, 1 ramping, 2 complete) and an error flag
//   (target above 100 percent; the command is ignored, but slow start still applies its start duty).
// Sequencing:
//   Commands that need no division go through accept, evaluate and deliver to
//   the result register. Ramp and slow-start commands with a nonzero step count,
//   and ticks that advance a ramp step, also run the shared bit-serial divider
//   in a divide step between evaluate and deliver, a tick with a multiply step
//   before it; the dividend is NUM_W = max(DUTY_FRAC_BITS + 14, 16) bits wide.
//   One command is in flight at a time; s_axis_tready is high only while the
//   sequencer waits.
// Reset: synchronous, active low; duty 0, state idle, ramp registers cleared.
// Stall: the result register holds a finished result while m_axis_tready is
//   low; the next command is still accepted and computed, then waits in the
//   deliver step until the result register frees up.
module pwm_duty_ramp_generator_top
    import pdrg_pkg::*;
#(
    parameter int DUTY_FRAC_BITS = 8,
    localparam int DW      = DUTY_FRAC_BITS + STEP_W,
    localparam int OUT_TW  = ((DW + MODE_W + 1 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] set_point, [31:16] start_duty, [47:32] ramp_ms
    input  logic [47:0]       s_axis_tdata,
    // [2:0] command
    input  logic [CMD_W-1:0]  s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [DW-1:0] duty_out, [DW+1:DW] ramp_state, [DW+2] error, zero fill above
    output logic [OUT_TW-1:0] m_axis_tdata
);

    localparam int CW    = (DW > FIELD_W) ? DW : FIELD_W;
    localparam int NUM_W = ((DW + STEP_W) > FIELD_W) ? (DW + STEP_W) : FIELD_W;
    localparam int PW    = DW + STEP_W;
    localparam logic [CW-1:0] DUTY_MAX = CW'(PCT_FULL << DUTY_FRAC_BITS);

    // Sequencer codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]         r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [FIELD_W-1:0] r_tgt, n_tgt;
    logic [FIELD_W-1:0] r_start, n_start;
    logic [FIELD_W-1:0] r_ms, n_ms;
    logic               r_err, n_err;

    // Ramp state.
    logic [DW-1:0]      r_duty, n_duty;
    logic [DW-1:0]      r_rs, n_rs;
    logic [DW-1:0]      r_rt, n_rt;
    logic [STEP_W-1:0]  r_total, n_total;
    logic [STEP_W-1:0]  r_idx, n_idx;
    logic [FIELD_W-1:0] r_delay, n_delay;
    logic [FIELD_W-1:0] r_elapsed, n_elapsed;
    t_mode              r_mode, n_mode;

    // Divider request.
    logic               r_div_start, n_div_start;
    logic [NUM_W-1:0]   r_dividend, n_dividend;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    // Result register.
    logic               r_out_valid, n_out_valid;
    logic [DW-1:0]      r_o_duty, n_o_duty;
    t_mode              r_o_mode, n_o_mode;
    logic               r_o_err, n_o_err;

    // Datapath terms.
    logic [CW-1:0]      c_tgt_cw;
    logic [CW-1:0]      c_start_cw;
    logic               c_bad;
    logic [DW-1:0]      c_tgt_d;
    logic [DW-1:0]      c_start_sat;
    logic [DW-1:0]      c_base;
    logic [DW-1:0]      c_diff;
    logic [STEP_W-1:0]  c_steps;
    logic [FIELD_W-1:0] c_elapsed_inc;
    logic [STEP_W:0]    c_idx_inc;
    logic               c_up;
    logic [DW-1:0]      c_range;
    logic [PW-1:0]      c_prod;
    logic [DW-1:0]      c_delta;
    logic [DW:0]        c_up_sum;
    logic [DW-1:0]      c_up_duty;
    logic [DW-1:0]      c_dn_diff;
    logic [DW-1:0]      c_dn_duty;

    assign c_tgt_cw    = CW'(r_tgt);
    assign c_start_cw  = CW'(r_start);
    assign c_bad       = (c_tgt_cw > DUTY_MAX);
    assign c_tgt_d     = c_tgt_cw[DW-1:0];
    assign c_start_sat = (c_start_cw > DUTY_MAX) ? DUTY_MAX[DW-1:0] : c_start_cw[DW-1:0];
    // Slow start ramps from the saturated start duty, a plain ramp from the present duty.
    assign c_base      = (r_cmd == CMD_SLOW) ? c_start_sat : r_duty;
    assign c_diff      = (c_tgt_d > c_base) ? (c_tgt_d - c_base) : (c_base - c_tgt_d);
    assign c_steps     = c_diff[DW-1 -: STEP_W];

    assign c_elapsed_inc = (r_elapsed != '1) ? (r_elapsed + 1'b1) : r_elapsed;
    assign c_idx_inc     = {1'b0, r_idx} + 1'b1;

    // Interpolation: start plus or minus range * index / total, clamped at the target.
    assign c_up      = (r_rt > r_rs);
    assign c_range   = c_up ? (r_rt - r_rs) : (r_rs - r_rt);
    assign c_prod    = PW'(c_range) * PW'(r_idx);
    assign c_delta   = div_quo[DW-1:0];
    assign c_up_sum  = {1'b0, r_rs} + {1'b0, c_delta};
    assign c_up_duty = (c_up_sum < {1'b0, r_rt}) ? c_up_sum[DW-1:0] : r_rt;
    assign c_dn_diff = (c_delta < r_rs) ? (r_rs - c_delta) : '0;
    assign c_dn_duty = (c_dn_diff > r_rt) ? c_dn_diff : r_rt;

    pdrg_divider #(
        .NUM_W(NUM_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_tgt       = r_tgt;
        n_start     = r_start;
        n_ms        = r_ms;
        n_err       = r_err;
        n_duty      = r_duty;
        n_rs        = r_rs;
        n_rt        = r_rt;
        n_total     = r_total;
        n_idx       = r_idx;
        n_delay     = r_delay;
        n_elapsed   = r_elapsed;
        n_mode      = r_mode;
        n_div_start = 1'b0;
        n_dividend  = r_dividend;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_o_duty    = r_o_duty;
        n_o_mode    = r_o_mode;
        n_o_err     = r_o_err;

        unique case (r_state)
            S_IDLE: begin
                // Capture the command transaction.
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser;
                    n_tgt   = s_axis_tdata[15:0];
                    n_start = s_axis_tdata[31:16];
                    n_ms    = s_axis_tdata[47:32];
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_err   = 1'b0;
                n_state = S_FIN;
                unique case (r_cmd)
                    CMD_TICK: begin
                        if (r_mode == MODE_RAMPING) begin
                            n_elapsed = c_elapsed_inc;
                            if (c_elapsed_inc >= r_delay) begin
                                // Step is due: land on the target or interpolate.
                                n_elapsed = '0;
                                n_idx     = c_idx_inc[STEP_W-1:0];
                                if (c_idx_inc >= {1'b0, r_total}) begin
                                    n_duty = r_rt;
                                    n_mode = MODE_COMPLETE;
                                end else begin
                                    n_state = S_MUL;
                                end
                            end
                        end
                    end
                    CMD_RAMP, CMD_SLOW: begin
                        if (r_cmd == CMD_SLOW) begin
                            n_duty = c_start_sat;
                        end
                        if (c_bad) begin
                            n_err = 1'b1;
                        end else begin
                            n_total   = c_steps;
                            n_rs      = c_base;
                            n_rt      = c_tgt_d;
                            n_idx     = '0;
                            n_elapsed = '0;
                            n_mode    = MODE_RAMPING;
                            if (c_steps == '0) begin
                                n_delay = '0;
                            end else begin
                                // Step delay = ramp time / steps.
                                n_dividend  = NUM_W'(r_ms);
                                n_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                    end
                    CMD_SET: begin
                        if (c_bad) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_mode == MODE_RAMPING) begin
                                n_mode = MODE_IDLE;
                            end
                            n_duty = c_tgt_d;
                            n_rs   = '0;
                            n_rt   = '0;
                        end
                    end
                    CMD_STOP: begin
                        n_mode = MODE_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                n_dividend  = NUM_W'(c_prod);
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_cmd == CMD_TICK) begin
                        n_duty = c_up ? c_up_duty : c_dn_duty;
                    end else begin
                        n_delay = div_quo[FIELD_W-1:0];
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the result register is free or being drained.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_o_duty    = r_duty;
                    n_o_mode    = r_mode;
                    n_o_err     = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_duty      <= '0;
            r_rs        <= '0;
            r_rt        <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_delay     <= '0;
            r_elapsed   <= '0;
            r_mode      <= MODE_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_duty      <= n_duty;
            r_rs        <= n_rs;
            r_rt        <= n_rt;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_delay     <= n_delay;
            r_elapsed   <= n_elapsed;
            r_mode      <= n_mode;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tgt      <= n_tgt;
        r_start    <= n_start;
        r_ms       <= n_ms;
        r_dividend <= n_dividend;
        r_o_duty   <= n_o_duty;
        r_o_mode   <= n_o_mode;
        r_o_err    <= n_o_err;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_o_err, r_o_mode, r_o_duty});

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_duty) <= DUTY_MAX)
        else $error("applied duty above full scale");

    a_step_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RAMPING) |-> (r_idx <= r_total))
        else $error("ramp step index past step count");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || m_axis_tready))
        |=> (r_state == S_IDLE && m_axis_tvalid))
        else $error("result not delivered to the result register");

endmodule

FILE: hw/rtl/pdrg_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, by a step-count divisor.
module pdrg_divider
    import pdrg_pkg::*;
#(
    parameter int NUM_W = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [STEP_W-1:0] i_divisor,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quotient
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_div;
    logic [STEP_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_quo;

    logic [STEP_W:0]   c_shift;
    logic              c_fit;
    logic [STEP_W:0]   c_sub;

    // Bring down the next dividend bit and try the subtraction.
    assign c_shift = {r_rem, r_quo[NUM_W-1]};
    assign c_fit   = (c_shift >= {1'b0, r_div});
    assign c_sub   = c_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= c_fit ? c_sub[STEP_W-1:0] : c_shift[STEP_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], c_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sim/pwm_duty_ramp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the PWM duty ramp generator: predicts every command's result and checks the output stream.
module pwm_duty_ramp_checker
    import pdrg_pkg::*;
#(
    parameter int DUTY_FRAC_BITS = 8,
    parameter int OUT_TW         = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    // [15:0] set_point, [31:16] start_duty, [47:32] ramp_ms
    input  logic [47:0]       i_s_tdata,
    // [2:0] command
    input  logic [CMD_W-1:0]  i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    // [DW-1:0] duty_out, [DW+1:DW] ramp_state, [DW+2] error, zero fill above
    input  logic [OUT_TW-1:0] i_m_tdata,
    output int                o_fail_count,
    output int                o_pending_count
);

    localparam int DW         = DUTY_FRAC_BITS + STEP_W;
    localparam int DUTY_FULL  = PCT_FULL << DUTY_FRAC_BITS;
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [DW-1:0] duty;
        t_mode         state;
        logic          err;
    } duty_result_t;

    duty_result_t duty_results_due[$];

    // Predicted ramp state.
    logic [DW-1:0]     duty_now;
    logic [DW-1:0]     ramp_from;
    logic [DW-1:0]     ramp_to;
    logic [STEP_W-1:0] steps_total;
    logic [7:0]        steps_done;
    logic [15:0]       step_wait;
    logic [15:0]       ms_since_step;
    t_mode             ramp_mode;

    initial o_fail_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < REPORT_CAP)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_ramp_state();
        duty_now      = '0;
        ramp_from     = '0;
        ramp_to       = '0;
        steps_total   = '0;
        steps_done    = '0;
        step_wait     = '0;
        ms_since_step = '0;
        ramp_mode     = MODE_IDLE;
    endtask

    // Launch a ramp from the present duty: one step per whole percent of distance.
    task automatic start_ramp(input logic [15:0] target, input logic [15:0] ms);
        int gap_abs;
        gap_abs = (target > duty_now) ? int'(target) - int'(duty_now)
                                      : int'(duty_now) - int'(target);
        steps_total   = STEP_W'(gap_abs >> DUTY_FRAC_BITS);
        step_wait     = (steps_total == 0) ? 16'd0 : 16'(int'(ms) / int'(steps_total));
        ramp_from     = duty_now;
        ramp_to       = DW'(target);
        steps_done    = '0;
        ms_since_step = '0;
        ramp_mode     = MODE_RAMPING;
    endtask

    // One millisecond: count toward the next step, then interpolate and clamp.
    task automatic advance_ms();
        int span;
        int delta;
        int nxt;
        if (ramp_mode != MODE_RAMPING)
            return;
        if (ms_since_step != 16'hFFFF)
            ms_since_step++;
        if (ms_since_step < step_wait)
            return;
        ms_since_step = '0;
        steps_done++;
        if (steps_done >= {1'b0, steps_total}) begin
            duty_now  = ramp_to;
            ramp_mode = MODE_COMPLETE;
            return;
        end
        if (ramp_to > ramp_from) begin
            span     = int'(ramp_to) - int'(ramp_from);
            delta    = span * int'(steps_done) / int'(steps_total);
            nxt      = int'(ramp_from) + delta;
            duty_now = (nxt < int'(ramp_to)) ? DW'(nxt) : ramp_to;
        end else begin
            span     = int'(ramp_from) - int'(ramp_to);
            delta    = span * int'(steps_done) / int'(steps_total);
            nxt      = (delta < int'(ramp_from)) ? int'(ramp_from) - delta : 0;
            duty_now = (nxt > int'(ramp_to)) ? DW'(nxt) : ramp_to;
        end
    endtask

    task automatic predict_command(input t_cmd cmd, input logic [47:0] payload);
        logic [15:0]  target;
        logic [15:0]  start;
        logic [15:0]  ms;
        logic         rejected;
        duty_result_t res;
        target   = payload[15:0];
        start    = payload[31:16];
        ms       = payload[47:32];
        rejected = int'(target) > DUTY_FULL;
        res.err  = 1'b0;
        case (cmd)
            CMD_TICK: begin
                advance_ms();
            end
            CMD_RAMP: begin
                if (rejected)
                    res.err = 1'b1;
                else
                    start_ramp(target, ms);
            end
            CMD_SET: begin
                if (rejected) begin
                    res.err = 1'b1;
                end else begin
                    // a complete ramp stays complete, a running one drops to idle
                    if (ramp_mode == MODE_RAMPING)
                        ramp_mode = MODE_IDLE;
                    duty_now  = DW'(target);
                    ramp_from = '0;
                    ramp_to   = '0;
                end
            end
            CMD_STOP: begin
                ramp_mode = MODE_IDLE;
            end
            CMD_SLOW: begin
                // the start duty is applied even when the target is rejected
                duty_now = (int'(start) > DUTY_FULL) ? DW'(DUTY_FULL) : DW'(start);
                if (rejected)
                    res.err = 1'b1;
                else
                    start_ramp(target, ms);
            end
            default: begin
            end
        endcase
        res.duty  = duty_now;
        res.state = ramp_mode;
        duty_results_due.push_back(res);
    endtask

    task automatic check_result(input logic [OUT_TW-1:0] bus);
        duty_result_t want;
        if (duty_results_due.size() == 0) begin
            report_mismatch("unrequested result, duty", int'(bus[DW-1:0]), -1);
            return;
        end
        want = duty_results_due.pop_front();
        if (bus[DW-1:0] !== want.duty)
            report_mismatch("duty_out", int'(bus[DW-1:0]), int'(want.duty));
        if (bus[DW+MODE_W-1:DW] !== want.state)
            report_mismatch("ramp_state", int'(bus[DW+MODE_W-1:DW]), int'(want.state));
        if (bus[DW+MODE_W] !== want.err)
            report_mismatch("error", int'(bus[DW+MODE_W]), int'(want.err));
        if ((bus >> (DW + MODE_W + 1)) !== '0)
            report_mismatch("tdata fill", int'(bus >> (DW + MODE_W + 1)), 0);
    endtask

    // Retire the result first: it always belongs to an earlier command.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_ramp_state();
            duty_results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                predict_command(i_s_tuser, i_s_tdata);
        end
        o_pending_count = duty_results_due.size();
    end

endmodule

FILE: sim/pwm_duty_ramp_generator_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the PWM duty ramp generator: clock, reset, command stimulus and verdict.
module pwm_duty_ramp_generator_top_test;
    import pdrg_pkg::*;

    localparam int FRAC          = 8;
    localparam int DW            = FRAC + STEP_W;
    localparam int OUT_TW        = ((DW + MODE_W + 1 + 7) / 8) * 8;
    localparam int DUTY_FULL     = PCT_FULL << FRAC;
    // Directed commands plus the random body; the last tick run overshoots a little.
    localparam int TOTAL_ITEMS   = 440;
    localparam int MIDRUN_DRAIN  = 250;
    // Leave room after the last drain for stray results.
    localparam int SETTLE_CYCLES = 40;
    // Hung-run limit, well above the slowest run of ~500 commands with idle gaps
    // on both sides and a divider run each.
    localparam int CYCLE_LIMIT   = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata;
    logic [CMD_W-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_TW-1:0] m_axis_tdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int sent_count  = 0;
    bit src_calm    = 1'b0;
    bit sink_calm   = 1'b0;

    pwm_duty_ramp_generator_top #(
        .DUTY_FRAC_BITS(FRAC)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pwm_duty_ramp_checker #(
        .DUTY_FRAC_BITS(FRAC),
        .OUT_TW        (OUT_TW)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: mostly ready, short stalls, the odd long one, calm stretches.
    initial begin
        int r;
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 149) == 0)
                sink_calm = !sink_calm;
            r = $urandom_range(0, 99);
            if (sink_calm || r < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                hold = (r < 96) ? $urandom_range(1, 4) : $urandom_range(15, 60);
                repeat (hold - 1) @(negedge i_clk);
            end
        end
    end

    // Present one command from a falling edge, hold it until the transaction
    // completes, then idle for a random gap. With no gap, tvalid stays high and
    // the next call replaces the payload on the same falling edge.
    task automatic push_cmd(input t_cmd cmd, input logic [15:0] target,
                            input logic [15:0] start, input logic [15:0] ms);
        int r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ms, start, target};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        @(negedge i_clk);
        r   = $urandom_range(0, 99);
        gap = (src_calm || r < 55) ? 0 :
              (r < 88) ? $urandom_range(1, 3) :
              (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop tvalid and hold off until every result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Valid targets: often the extremes, otherwise anywhere, with a bias to
    // low duties so that many ramps are short.
    function automatic logic [15:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'd0;
        if (r < 16)
            return 16'(DUTY_FULL);
        if (r < 60)
            return 16'($urandom_range(0, DUTY_FULL));
        return 16'($urandom_range(0, DUTY_FULL / 8));
    endfunction

    // Ramp times: short so ramps finish within a run of ticks, sometimes any value.
    function automatic logic [15:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(0, 30));
        if (r < 90)
            return 16'($urandom_range(0, 400));
        return 16'($urandom);
    endfunction

    initial begin
        int  r;
        int  n_ticks;
        bit  drained_mid;
        t_cmd cmd;
        drained_mid   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        push_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);             // tick while idle
        push_cmd(CMD_SET, 16'(DUTY_FULL), 16'hFFFF, 16'hFFFF);        // full duty
        push_cmd(CMD_SET, 16'(DUTY_FULL + 1), 16'h0000, 16'h0000);    // just above full: rejected
        push_cmd(CMD_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF);              // largest target: rejected
        push_cmd(CMD_RAMP, 16'd0, 16'h0000, 16'd0);                   // 100 steps, no delay
        push_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(CMD_SET, 16'd12800, 16'h0000, 16'h0000);             // set stops the ramp
        push_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(CMD_RAMP, 16'd12900, 16'h0000, 16'd500);             // under one percent: zero steps
        push_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);             // completes on the target
        push_cmd(CMD_SET, 16'd0, 16'h0000, 16'h0000);                 // complete stays complete
        push_cmd(CMD_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(CMD_SLOW, 16'd0, 16'hFFFF, 16'hFFFF);                // start duty saturates
        push_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(CMD_SLOW, 16'd30000, 16'd1000, 16'd10);              // rejected, start still applied
        push_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(CMD_STOP, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(t_cmd'(5), 16'hFFFF, 16'hFFFF, 16'hFFFF);            // unused codes: no effect
        push_cmd(t_cmd'(6), 16'd100, 16'd100, 16'd100);
        push_cmd(t_cmd'(7), 16'h0000, 16'h0000, 16'h0000);
        push_cmd(CMD_SLOW, 16'd512, 16'd0, 16'hFFFF);                 // two steps, long delay
        push_cmd(CMD_RAMP, 16'(DUTY_FULL), 16'h0000, 16'd3);          // rising ramp, delay 0
        push_cmd(CMD_TICK, 16'h5555, 16'hAAAA, 16'h5555);
        push_cmd(CMD_TICK, 16'hAAAA, 16'h5555, 16'hAAAA);
        drain_results();

        // Random part: a ramp-type command followed by a run of ticks, mixed
        // with sets, stops, rejected targets and unused codes.
        while (sent_count < TOTAL_ITEMS) begin
            src_calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_cmd(CMD_RAMP, pick_target(), 16'($urandom), pick_ms());
            end else if (r < 70) begin
                push_cmd(CMD_SLOW, pick_target(),
                         ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, DUTY_FULL)),
                         pick_ms());
            end else if (r < 78) begin
                push_cmd(CMD_SET, pick_target(), 16'($urandom), 16'($urandom));
            end else if (r < 85) begin
                push_cmd(CMD_STOP, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 93) begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_RAMP;
                    1:       cmd = CMD_SET;
                    default: cmd = CMD_SLOW;
                endcase
                push_cmd(cmd, 16'($urandom_range(DUTY_FULL + 1, 65535)),
                         16'($urandom), 16'($urandom));
            end else if (r < 96) begin
                push_cmd(t_cmd'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end
            n_ticks = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12)
                                                   : $urandom_range(20, 110);
            repeat (n_ticks)
                push_cmd(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
            if (!drained_mid && sent_count >= MIDRUN_DRAIN) begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
